// ===== rtl/pabc_pkg.sv =====
// ----------------------------------------------------------------------------
// pabc_pkg
// Shared constants, types and control bundle of the point axis bin counter.
// ----------------------------------------------------------------------------
package pabc_pkg;

  localparam int COORD_W = 32;
  localparam int COUNT_W = 32;
  localparam int WIDTH_W = 14;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 14'd100;

  localparam int METERS_PER_AXIS = 64;
  localparam int MAX_SEGMENTS = 256;

  // x / 10000 for 32-bit x is (x * RECIP) >> RECIP_SHIFT, exact over the range
  localparam int UNITS_PER_METER = 10000;
  localparam logic [COORD_W-1:0] RECIP = 32'hD1B7_1759;
  localparam int RECIP_SHIFT = 45;
  localparam int PROD_W = 2 * COORD_W;
  localparam int QUO_W = PROD_W - RECIP_SHIFT;
  localparam int KEY_W = QUO_W;
  localparam int REM_W = 14;

  localparam int SLOT_W = (METERS_PER_AXIS > 1) ? $clog2(METERS_PER_AXIS) : 1;
  localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int MEM_AW = SLOT_W + SEG_W;

  // divider retires two quotient bits per cycle; divide also spans compare and encode
  localparam int DIV_CYCLES = ((SEG_W + 1) / 2 > 2) ? (SEG_W + 1) / 2 : 2;
  localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

  typedef struct packed {
    logic              clr;
    logic [MEM_AW-1:0] clr_addr;
    logic              load;
    logic              mul;
    logic              rem;
    logic              step;
    logic              cmp;
    logic              enc;
    logic              rd;
    logic              wr;
  } ctl_t;

endpackage

// ===== rtl/pabc_if.sv =====
// ----------------------------------------------------------------------------
// pabc_if
// Valid/ready channels of the point axis bin counter.
// ----------------------------------------------------------------------------
interface pabc_pt_if import pabc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [COORD_W-1:0] z_coord;

  modport source(output valid, output x_coord, output y_coord, output z_coord,
                 input ready);
  modport sink(input valid, input x_coord, input y_coord, input z_coord,
               output ready);
endinterface

interface pabc_cnt_if import pabc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] x_bin_count;
  logic [COUNT_W-1:0] y_bin_count;
  logic [COUNT_W-1:0] z_bin_count;
  logic               x_table_full;
  logic               y_table_full;
  logic               z_table_full;

  modport source(output valid, output x_bin_count, output y_bin_count,
                 output z_bin_count, output x_table_full, output y_table_full,
                 output z_table_full, input ready);
  modport sink(input valid, input x_bin_count, input y_bin_count,
               input z_bin_count, input x_table_full, input y_table_full,
               input z_table_full, output ready);
endinterface

interface pabc_cfg_if import pabc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] segment_width;

  modport source(output valid, output segment_width, input ready);
  modport sink(input valid, input segment_width, output ready);
endinterface

// ===== rtl/pabc_div.sv =====
// ----------------------------------------------------------------------------
// pabc_div
// Restoring divider, two quotient bits per cycle, saturating segment index.
// ----------------------------------------------------------------------------
module pabc_div import pabc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               step,
  input  logic [REM_W-1:0]   dividend,
  input  logic [WIDTH_W-1:0] divisor,
  output logic [SEG_W-1:0]   seg
);

  localparam int DSH_W = WIDTH_W + SEG_W;
  localparam int LEFT_W = $clog2(SEG_W + 1);

  logic [REM_W-1:0]  r;
  logic [DSH_W-1:0]  dsh;
  logic [SEG_W-1:0]  q;
  logic [LEFT_W-1:0] left;
  logic              first;
  logic              ovf;

  logic [REM_W-1:0]  r_next;
  logic [DSH_W-1:0]  dsh_next;
  logic [SEG_W-1:0]  q_next;
  logic [LEFT_W-1:0] left_next;

  always_comb begin
    r_next    = r;
    dsh_next  = dsh;
    q_next    = q;
    left_next = left;
    for (int k = 0; k < 2; k++) begin
      if (left_next != '0) begin
        if (DSH_W'(r_next) >= dsh_next) begin
          r_next = r_next - REM_W'(dsh_next);
          q_next = (q_next << 1) | SEG_W'(1);
        end else begin
          q_next = q_next << 1;
        end
        dsh_next  = dsh_next >> 1;
        left_next = left_next - LEFT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left  <= '0;
      first <= 1'b0;
      ovf   <= 1'b0;
    end else if (start) begin
      left  <= LEFT_W'(SEG_W);
      first <= 1'b1;
    end else if (step) begin
      left  <= left_next;
      first <= 1'b0;
      // quotient too wide for the segment field: pin to the top segment
      if (first) begin
        ovf <= DSH_W'(r) >= (dsh << 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r   <= dividend;
      dsh <= DSH_W'(divisor) << (SEG_W - 1);
      q   <= '0;
    end else if (step) begin
      r   <= r_next;
      dsh <= dsh_next;
      q   <= q_next;
    end
  end

  always_comb begin
    if (ovf || ({1'b0, q} >= (SEG_W + 1)'(MAX_SEGMENTS))) begin
      seg = SEG_W'(MAX_SEGMENTS - 1);
    end else begin
      seg = q;
    end
  end

endmodule

// ===== rtl/pabc_axis.sv =====
// ----------------------------------------------------------------------------
// pabc_axis
// One axis: meter split, key table lookup/claim and count memory update.
// ----------------------------------------------------------------------------
module pabc_axis import pabc_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  ctl_t                      ctl,
  input  logic signed [COORD_W-1:0] coord,
  input  logic [WIDTH_W-1:0]        width,
  output logic [COUNT_W-1:0]        count,
  output logic                      full
);

  localparam logic [REM_W-1:0] UNITS = REM_W'(UNITS_PER_METER);
  localparam int MEM_DEPTH = 1 << MEM_AW;

  logic [COORD_W-1:0] coord_u;
  logic [COORD_W-1:0] mag;
  logic               neg;
  logic [PROD_W-1:0]  prod;
  logic [QUO_W-1:0]   quo;
  logic [REM_W-1:0]   rest;
  logic [KEY_W-1:0]   key;
  logic [SEG_W-1:0]   seg;

  logic [METERS_PER_AXIS-1:0] valid;
  logic [KEY_W-1:0]           keys [0:METERS_PER_AXIS-1];
  logic [METERS_PER_AXIS-1:0] hit_vec;
  logic [METERS_PER_AXIS-1:0] free_vec;
  logic                       hit_any;
  logic                       free_any;
  logic [SLOT_W-1:0]          hit_idx;
  logic [SLOT_W-1:0]          free_idx;
  logic [SLOT_W-1:0]          slot;
  logic                       hit;
  logic                       avail;

  logic [COUNT_W-1:0] mem [0:MEM_DEPTH-1];
  logic [COUNT_W-1:0] rd_data;
  logic [MEM_AW-1:0]  addr;
  logic [COUNT_W-1:0] inc;

  assign coord_u = coord;
  assign quo     = prod[PROD_W-1:RECIP_SHIFT];
  // remainder is below 2^REM_W, so the low bits of the product suffice
  assign rest    = mag[REM_W-1:0] - REM_W'(quo[REM_W-1:0] * UNITS);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      neg <= coord_u[COORD_W-1];
      mag <= coord_u[COORD_W-1] ? (COORD_W'(0) - coord_u) : coord_u;
    end
    if (ctl.mul) begin
      prod <= mag * RECIP;
    end
    if (ctl.rem) begin
      key <= neg ? (KEY_W'(0) - quo) : quo;
    end
  end

  pabc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.rem),
    .step     (ctl.step),
    .dividend (rest),
    .divisor  (width),
    .seg      (seg)
  );

  // key table: every entry compared in parallel, then priority encoded
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      for (int i = 0; i < METERS_PER_AXIS; i++) begin
        hit_vec[i]  <= valid[i] && (keys[i] == key);
        free_vec[i] <= !valid[i];
      end
    end
  end

  always_comb begin
    hit_any  = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = METERS_PER_AXIS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_any = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (free_vec[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.enc) begin
      slot  <= hit_any ? hit_idx : free_idx;
      hit   <= hit_any;
      avail <= hit_any || free_any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctl.wr && avail && !hit) begin
      valid[slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && avail && !hit) begin
      keys[slot] <= key;
    end
  end

  // count memory: read at rd, write back at wr, zero sweep after reset
  assign addr = {slot, seg};
  assign inc  = (&rd_data) ? rd_data : rd_data + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      mem[ctl.clr_addr] <= '0;
    end else if (ctl.wr && avail) begin
      mem[addr] <= inc;
    end
    if (ctl.rd) begin
      rd_data <= mem[addr];
    end
  end

  assign count = avail ? inc : '0;
  assign full  = !avail;

endmodule

// ===== rtl/point_axis_bin_counter.sv =====
// ----------------------------------------------------------------------------
// point_axis_bin_counter
// Per-axis meter/segment histogram of 3D points with saturating counts.
// ----------------------------------------------------------------------------
//   port     dir   beat contents
//   points   in    x_coord, y_coord, z_coord (signed, 0.1 mm)
//   counts   out   x/y/z_bin_count, x/y/z_table_full
//   cfg      in    segment_width
//
// Per point: accept, reciprocal multiply, remainder, divider steps (2 quotient
// bits each, key match overlapped), count read, write back; a new point is
// accepted only once the last is written back. After reset a zero sweep clears
// every count memory word; points.ready stays low until it ends.
// cfg.ready is always high. A result beat waits in the output register; the
// write back stalls only while that register is still held by the sink.
// ----------------------------------------------------------------------------
module point_axis_bin_counter import pabc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pabc_pt_if.sink     points,
  pabc_cnt_if.source  counts,
  pabc_cfg_if.sink    cfg
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_REM   = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_RD    = 7'b0100000,
    S_WR    = 7'b1000000
  } state_t;

  state_t                 state;
  state_t                 state_next;
  logic [MEM_AW-1:0]      clr_addr;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [WIDTH_W-1:0]     seg_width;
  logic [WIDTH_W-1:0]     width_eff;
  logic                   out_free;
  logic                   wr_fire;
  ctl_t                   ctl;

  logic [COUNT_W-1:0] x_cnt;
  logic [COUNT_W-1:0] y_cnt;
  logic [COUNT_W-1:0] z_cnt;
  logic               x_full;
  logic               y_full;
  logic               z_full;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_width <= WIDTH_RESET;
    end else if (cfg.valid) begin
      seg_width <= cfg.segment_width;
    end
  end

  assign width_eff    = (seg_width == '0) ? WIDTH_W'(1) : seg_width;
  assign points.ready = (state == S_IDLE);
  assign out_free     = !counts.valid || counts.ready;
  assign wr_fire      = (state == S_WR) && out_free;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (&clr_addr) state_next = S_IDLE;
      S_IDLE:  if (points.valid) state_next = S_MUL;
      S_MUL:   state_next = S_REM;
      S_REM:   state_next = S_DIV;
      S_DIV:   if (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) state_next = S_RD;
      S_RD:    state_next = S_WR;
      S_WR:    if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      div_cnt  <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + MEM_AW'(1);
      end
      if (state == S_DIV) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end else begin
        div_cnt <= '0;
      end
    end
  end

  always_comb begin
    ctl.clr      = (state == S_CLEAR);
    ctl.clr_addr = clr_addr;
    ctl.load     = points.valid && points.ready;
    ctl.mul      = (state == S_MUL);
    ctl.rem      = (state == S_REM);
    ctl.step     = (state == S_DIV);
    ctl.cmp      = (state == S_DIV) && (div_cnt == DIV_CNT_W'(0));
    ctl.enc      = (state == S_DIV) && (div_cnt == DIV_CNT_W'(1));
    ctl.rd       = (state == S_RD);
    ctl.wr       = wr_fire;
  end

  pabc_axis u_x (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .coord (points.x_coord),
    .width (width_eff),
    .count (x_cnt),
    .full  (x_full)
  );

  pabc_axis u_y (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .coord (points.y_coord),
    .width (width_eff),
    .count (y_cnt),
    .full  (y_full)
  );

  pabc_axis u_z (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .coord (points.z_coord),
    .width (width_eff),
    .count (z_cnt),
    .full  (z_full)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      counts.valid <= 1'b0;
    end else if (wr_fire) begin
      counts.valid <= 1'b1;
    end else if (counts.ready) begin
      counts.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      counts.x_bin_count  <= x_cnt;
      counts.y_bin_count  <= y_cnt;
      counts.z_bin_count  <= z_cnt;
      counts.x_table_full <= x_full;
      counts.y_table_full <= y_full;
      counts.z_table_full <= z_full;
    end
  end

endmodule

// ===== dv/tb_point_axis_bin_counter.sv =====
// ----------------------------------------------------------------------------
// tb_point_axis_bin_counter
// Self-checking bench for the point axis bin counter. Points go in over the
// valid/ready channel; a scoreboard class keeps its own meter tables and
// segment counts, predicts every count beat and checks each result beat in
// order. Directed points cover coordinate extremes and segment width corners.
// Random blocks follow, each under a new width, mostly on a pool of recurring
// meters with some wide noise that fills the tables. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_point_axis_bin_counter;
  timeunit 1ns;
  timeprecision 1ps;
  import pabc_pkg::*;

  localparam int POOL_N = 40;
  localparam int STALL_LIMIT = 50000;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  typedef logic [2:0][COORD_W-1:0] coord3_t;

  typedef struct packed {
    logic [2:0][COUNT_W-1:0] cnt;
    logic [2:0]              full;
  } bins_t;

  // Tracks meter tables and bin counts; queues the count beat of each point.
  class bin_scoreboard;
    logic [WIDTH_W-1:0] seg_width;
    bit [KEY_W-1:0]     key_of [3][METERS_PER_AXIS];
    bit                 claimed [3][METERS_PER_AXIS];
    bit [COUNT_W-1:0]   tally [3][METERS_PER_AXIS][MAX_SEGMENTS];
    bins_t              pending [$];

    function new();
      seg_width = WIDTH_RESET;
    endfunction

    function void bin_axis(int a, logic [COORD_W-1:0] v, output logic [COUNT_W-1:0] n,
                           output logic full);
      logic [COORD_W-1:0] mag, q, rest, w, seg, skey;
      logic [KEY_W-1:0]   key;
      int                 slot, free_slot;
      mag = v[COORD_W-1] ? (32'd0 - v) : v;
      q = mag / UNITS_PER_METER;
      rest = mag % UNITS_PER_METER;
      // key is the truncated quotient, kept as KEY_W-bit two's complement
      skey = v[COORD_W-1] ? (32'd0 - q) : q;
      key = skey[KEY_W-1:0];
      w = (seg_width == '0) ? 32'd1 : 32'(seg_width);
      seg = rest / w;
      if (seg >= MAX_SEGMENTS) seg = MAX_SEGMENTS - 1;
      slot = -1;
      free_slot = -1;
      for (int i = 0; i < METERS_PER_AXIS; i++) begin
        if (claimed[a][i]) begin
          if (slot < 0 && key_of[a][i] == key) slot = i;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (slot < 0) begin
        if (free_slot < 0) begin
          full = 1'b1;
          n = '0;
          return;
        end
        slot = free_slot;
        claimed[a][slot] = 1'b1;
        key_of[a][slot] = key;
      end
      full = 1'b0;
      if (tally[a][slot][seg] != '1) tally[a][slot][seg]++;
      n = tally[a][slot][seg];
    endfunction

    function void note_point(coord3_t c);
      bins_t              e;
      logic [COUNT_W-1:0] n;
      logic               f;
      for (int a = 0; a < 3; a++) begin
        bin_axis(a, c[a], n, f);
        e.cnt[a] = n;
        e.full[a] = f;
      end
      pending.push_back(e);
    endfunction

    function bit check_counts(bins_t got, output string why);
      bins_t want;
      bit    ok;
      if (pending.size() == 0) begin
        why = $sformatf("count beat %h/%h/%h full %b with no point pending",
                        got.cnt[0], got.cnt[1], got.cnt[2], got.full);
        return 1'b0;
      end
      want = pending.pop_front();
      ok = 1'b1;
      why = "count beat mismatch:";
      for (int a = 0; a < 3; a++) begin
        if (got.cnt[a] !== want.cnt[a]) begin
          ok = 1'b0;
          why = {why, $sformatf(" axis%0d count %h exp %h", a, got.cnt[a], want.cnt[a])};
        end
        if (got.full[a] !== want.full[a]) begin
          ok = 1'b0;
          why = {why, $sformatf(" axis%0d full %b exp %b", a, got.full[a], want.full[a])};
        end
      end
      return ok;
    endfunction
  endclass

  logic clk;
  logic rst;

  pabc_pt_if  pt_if ();
  pabc_cnt_if cnt_if ();
  pabc_cfg_if cfg_if ();

  point_axis_bin_counter u_top (
    .clk    (clk),
    .rst    (rst),
    .points (pt_if),
    .counts (cnt_if),
    .cfg    (cfg_if)
  );

  bin_scoreboard sb;
  int            errors;
  int            idle_cycles;
  int            hold;
  bit            quiet;
  int            key_pool [3][POOL_N];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(string what);
    errors++;
    if (errors <= 100) $display("ERROR %0t: %s", $realtime, what);
  endtask

  function automatic coord3_t pt3(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [COORD_W-1:0] z);
    coord3_t c;
    c[0] = x;
    c[1] = y;
    c[2] = z;
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // meter k plus a remainder, sign taken from the meter (or neg for meter 0)
  function automatic logic [COORD_W-1:0] mk_coord(int k, int r, bit neg);
    longint v;
    v = longint'(k) * 10000;
    if (k < 0 || (k == 0 && neg)) v = v - r;
    else v = v + r;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return 32'(v);
  endfunction

  function automatic logic [COORD_W-1:0] rnd_coord(int a);
    int r, k, rest;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom;
    if (r < 18) return mk_coord(int'($urandom_range(0, 2)) - 1, $urandom_range(0, 9999),
                                1'($urandom_range(0, 1)));
    k = key_pool[a][$urandom_range(0, POOL_N - 1)];
    case ($urandom_range(0, 4))
      0: rest = 0;
      1: rest = 9999;
      default: rest = $urandom_range(0, 9999);
    endcase
    return mk_coord(k, rest, 1'($urandom_range(0, 1)));
  endfunction

  // valid stays up across back-to-back beats; only dropped ahead of a gap
  task automatic send_point(coord3_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pt_if.valid   <= 1'b1;
    pt_if.x_coord <= c[0];
    pt_if.y_coord <= c[1];
    pt_if.z_coord <= c[2];
    do @(posedge clk); while (!pt_if.ready);
  endtask

  task automatic drain();
    pt_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(logic [WIDTH_W-1:0] w);
    drain();
    cfg_if.valid         <= 1'b1;
    cfg_if.segment_width <= w;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // count sink with random stalls
  always @(posedge clk) begin
    if (hold > 0) begin
      cnt_if.ready <= 1'b0;
      hold <= hold - 1;
    end else begin
      cnt_if.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) hold <= pick_gap();
    end
  end

  always @(posedge clk) begin : mon
    bins_t got;
    string why;
    bit    moved;
    moved = 1'b0;
    if (!rst && cfg_if.valid && cfg_if.ready) begin
      sb.seg_width = cfg_if.segment_width;
      moved = 1'b1;
    end
    if (!rst && pt_if.valid && pt_if.ready) begin
      sb.note_point(pt3(pt_if.x_coord, pt_if.y_coord, pt_if.z_coord));
      moved = 1'b1;
    end
    if (!rst && cnt_if.valid === 1'b1 && cnt_if.ready) begin
      got.cnt[0]  = cnt_if.x_bin_count;
      got.cnt[1]  = cnt_if.y_bin_count;
      got.cnt[2]  = cnt_if.z_bin_count;
      got.full[0] = cnt_if.x_table_full;
      got.full[1] = cnt_if.y_table_full;
      got.full[2] = cnt_if.z_table_full;
      if (!sb.check_counts(got, why)) report(why);
      moved = 1'b1;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    // covers the post-reset clearing sweep with margin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_point_axis_bin_counter: FAIL");
      $finish;
    end
  end

  initial begin
    logic [WIDTH_W-1:0] widths [8];
    rst                  = 1'b1;
    pt_if.valid          = 1'b0;
    pt_if.x_coord        = '0;
    pt_if.y_coord        = '0;
    pt_if.z_coord        = '0;
    cnt_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.segment_width = WIDTH_RESET;
    errors               = 0;
    idle_cycles          = 0;
    hold                 = 0;
    quiet                = 1'b0;
    sb = new();
    for (int a = 0; a < 3; a++) begin
      key_pool[a][0] = 0;
      key_pool[a][1] = 214748;
      key_pool[a][2] = -214748;
      key_pool[a][3] = 1;
      key_pool[a][4] = -1;
      for (int i = 5; i < POOL_N; i++)
        key_pool[a][i] = $urandom_range(0, 1) ? int'($urandom_range(0, 40)) - 20
                                              : int'($urandom_range(0, 429496)) - 214748;
    end
    widths = '{14'd40, 14'd10000, 14'd16383, 14'd0, 14'd1, 14'd39,
               14'($urandom_range(40, 10000)), 14'($urandom_range(0, 16383))};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset width: coordinate extremes, meter boundaries, negative zero meter
    send_point(pt3(0, 0, 0));
    send_point(pt3(0, 0, 0));
    send_point(pt3(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
    send_point(pt3(32'h8000_0000, 32'h7FFF_FFFF, 9999));
    send_point(pt3(9999, -9999, 10000));
    send_point(pt3(-10000, 10000, -1));
    send_point(pt3(-1, 99, 100));

    // zero width acts as one, segment clamps to the last bin
    write_width(14'd0);
    send_point(pt3(9999, -9999, 255));
    send_point(pt3(256, -255, 0));
    // below the legal range: still clamps
    write_width(14'd39);
    send_point(pt3(9999, 9945, -9984));
    send_point(pt3(9984, -9945, 39));
    write_width(14'd40);
    send_point(pt3(9999, -40, 39));
    send_point(pt3(-9999, 40, -39));
    write_width(14'd10000);
    send_point(pt3(9999, -9999, 32'h7FFF_FFFF));
    send_point(pt3(0, 32'h8000_0000, -1));
    write_width(14'd16383);
    send_point(pt3(9999, 1, 32'h8000_0000));
    send_point(pt3(-9999, 32'h7FFF_FFFF, 0));

    for (int b = 0; b < 8; b++) begin
      write_width(widths[b]);
      quiet = (b == 2 || b == 5);
      for (int n = 0; n < 200; n++)
        send_point(pt3(rnd_coord(0), rnd_coord(1), rnd_coord(2)));
    end
    quiet = 1'b0;

    drain();
    repeat (30) @(posedge clk);
    if (sb.pending.size() != 0)
      report($sformatf("%0d count beats never arrived", sb.pending.size()));
    if (errors == 0) begin
      $display("tb_point_axis_bin_counter: PASS");
    end else begin
      $display("tb_point_axis_bin_counter: FAIL");
    end
    $finish;
  end

endmodule
